/* design/sgrc_pkg.sv */
// Shared types, constants, tables and the sweep target function of the sound generator.
`timescale 1ns / 1ps
package sgrc_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_DELIVER = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] reg_offset;
        logic [7:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq_line;
        logic        fetch_request;
        logic [15:0] fetch_address;
        logic [2:0]  stall_cycles;
        logic [3:0]  pulse_one_level;
        logic [3:0]  pulse_two_level;
        logic [3:0]  triangle_level;
        logic [3:0]  noise_level;
        logic [6:0]  sample_level;
    } t_out_word;

    // channel state that the level gating looks at
    typedef struct packed {
        logic [1:0][7:0]  pulse_ctl;
        logic [1:0][7:0]  sweep_ctl;
        logic [1:0][10:0] pulse_period;
        logic [1:0][2:0]  duty_step;
        logic [2:0][3:0]  env_decay;
        logic [3:0]       len_nz;
        logic [4:0]       enables;
        logic [10:0]      tri_period;
        logic [4:0]       tri_step;
        logic             linear_nz;
        logic [7:0]       noise_ctl;
        logic             lfsr_lsb;
    } t_lvl_state;

    localparam logic [4:0]  OFF_PULSE_END = 5'd8;
    localparam logic [4:0]  OFF_TRI_END   = 5'd12;
    localparam logic [4:0]  OFF_NOISE_END = 5'd16;
    localparam logic [4:0]  OFF_DMC_END   = 5'd20;
    localparam logic [4:0]  OFF_TRI_HI    = 5'd11;
    localparam logic [4:0]  OFF_NOISE_HI  = 5'd15;
    localparam logic [4:0]  OFF_DMC_CTRL  = 5'd16;
    localparam logic [4:0]  OFF_DMC_LEVEL = 5'd17;
    localparam logic [4:0]  OFF_STATUS    = 5'd21;
    localparam logic [4:0]  OFF_FRAME     = 5'd23;

    localparam logic [15:0] DMC_BASE      = 16'hC000;
    localparam logic [15:0] DMC_WRAP_FROM = 16'hFFFF;
    localparam logic [15:0] DMC_WRAP_TO   = 16'h8000;
    localparam logic [15:0] PERIOD_MAX    = 16'h07FF;
    localparam logic [15:0] FRAME_Q1      = 16'd7457;
    localparam logic [15:0] FRAME_Q2      = 16'd14913;
    localparam logic [15:0] FRAME_Q3      = 16'd22371;
    localparam logic [15:0] FRAME_END4    = 16'd29829;
    localparam logic [15:0] FRAME_END5    = 16'd37281;
    localparam logic [6:0]  DMC_TOP       = 7'd125;
    localparam logic [2:0]  STALL_FETCH   = 3'd4;

    localparam logic [7:0] LEN_LUT [32] = '{
        8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
        8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };
    localparam logic [11:0] NOISE_LUT [16] = '{
        12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
        12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068
    };
    localparam logic [8:0] RATE_LUT [16] = '{
        9'd428, 9'd380, 9'd340, 9'd320, 9'd286, 9'd254, 9'd226, 9'd214,
        9'd190, 9'd160, 9'd142, 9'd128, 9'd106, 9'd85, 9'd72, 9'd54
    };
    localparam logic [7:0] DUTY_LUT [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

    // sweep target, 16-bit wrap in negate mode; first pulse subtracts one more
    function automatic logic [15:0] sweep_goal(input logic [10:0] period,
                                               input logic [7:0] ctl,
                                               input logic first);
        logic [15:0] t;
        logic [15:0] d;
        t = {5'd0, period};
        d = t >> ctl[2:0];
        if (ctl[2:0] == 3'd0) begin
            sweep_goal = t;
        end else if (ctl[3]) begin
            sweep_goal = t - d - {15'd0, first};
        end else begin
            sweep_goal = t + d;
        end
    endfunction

endpackage

/* design/sgrc_levels.sv */
// Gated digital levels of the pulse, triangle and noise channels.
`timescale 1ns / 1ps
module sgrc_levels (
    input  sgrc_pkg::t_lvl_state i_st,
    output logic [3:0]           o_pulse_one,
    output logic [3:0]           o_pulse_two,
    output logic [3:0]           o_triangle,
    output logic [3:0]           o_noise
);
    import sgrc_pkg::*;

    logic [1:0][3:0] pulse_lvl;
    logic [7:0]      duty;

    always_comb begin
        duty = '0;
        for (int ch = 0; ch < 2; ch++) begin
            duty = DUTY_LUT[i_st.pulse_ctl[ch][7:6]];
            pulse_lvl[ch] = '0;
            if (i_st.enables[ch] && i_st.len_nz[ch] && i_st.pulse_period[ch] >= 11'd8 &&
                sweep_goal(i_st.pulse_period[ch], i_st.sweep_ctl[ch], ch == 0) <= PERIOD_MAX &&
                duty[i_st.duty_step[ch]]) begin
                pulse_lvl[ch] = i_st.pulse_ctl[ch][4] ? i_st.pulse_ctl[ch][3:0]
                                                      : i_st.env_decay[ch];
            end
        end
    end

    assign o_pulse_one = pulse_lvl[0];
    assign o_pulse_two = pulse_lvl[1];

    always_comb begin
        o_triangle = '0;
        if (i_st.enables[2] && i_st.len_nz[2] && i_st.linear_nz && i_st.tri_period >= 11'd2) begin
            o_triangle = i_st.tri_step[4] ? i_st.tri_step[3:0] : ~i_st.tri_step[3:0];
        end
    end

    always_comb begin
        o_noise = '0;
        if (i_st.enables[3] && i_st.len_nz[3] && !i_st.lfsr_lsb) begin
            o_noise = i_st.noise_ctl[4] ? i_st.noise_ctl[3:0] : i_st.env_decay[2];
        end
    end

endmodule

/* design/sound_generator_register_core.sv */
// Sound generator register core: pulse, triangle, noise and sample channels with frame sequencer.
//
// Input channel: one word per item (register write, status read, clock tick or
// sample byte delivery) on i_in_valid / o_in_ready. Output channel: one word per
// item on o_out_valid / i_out_ready, carrying status read data, irq line, the
// sample fetch request and address, stall cycles and the five channel levels.
// Each item updates the whole channel state in the cycle it is accepted; its
// result is registered and shown on the next cycle.
// Throughput is one item per cycle: the output register frees as it is taken,
// so o_in_ready stays high while the receiver keeps up. When the receiver
// stalls, the finished word holds and o_in_ready drops until it is taken.
// A fetch request asks for the byte at fetch_address; the byte comes back in a
// later delivery item. Synchronous reset puts all channel state to its idle
// values (noise shift register one, sample buffer empty and silent) and
// empties the output register.
`timescale 1ns / 1ps
module sound_generator_register_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sgrc_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sgrc_pkg::t_out_word  o_out_word
);
    import sgrc_pkg::*;

    logic [7:0]  r_pulse_reg [8],  n_pulse_reg [8];
    logic [7:0]  r_tri_reg [4],    n_tri_reg [4];
    logic [7:0]  r_noise_reg [4],  n_noise_reg [4];
    logic [7:0]  r_dmc_reg [4],    n_dmc_reg [4];
    logic [7:0]  r_len [4],        n_len [4];
    logic        r_env_start [3],  n_env_start [3];
    logic [3:0]  r_env_div [3],    n_env_div [3];
    logic [3:0]  r_env_decay [3],  n_env_decay [3];
    logic [2:0]  r_sweep_div [2],  n_sweep_div [2];
    logic        r_sweep_rld [2],  n_sweep_rld [2];
    logic [10:0] r_pulse_cnt [2],  n_pulse_cnt [2];
    logic [2:0]  r_duty_step [2],  n_duty_step [2];
    logic [10:0] r_tri_cnt,        n_tri_cnt;
    logic [4:0]  r_tri_step,       n_tri_step;
    logic [6:0]  r_linear,         n_linear;
    logic        r_linear_rld,     n_linear_rld;
    logic [11:0] r_noise_cnt,      n_noise_cnt;
    logic [14:0] r_lfsr,           n_lfsr;
    logic [8:0]  r_dmc_cnt,        n_dmc_cnt;
    logic [6:0]  r_dmc_out,        n_dmc_out;
    logic [15:0] r_dmc_addr,       n_dmc_addr;
    logic [11:0] r_dmc_left,       n_dmc_left;
    logic [7:0]  r_dmc_shift,      n_dmc_shift;
    logic [3:0]  r_dmc_bits,       n_dmc_bits;
    logic [7:0]  r_dmc_buf,        n_dmc_buf;
    logic        r_dmc_empty,      n_dmc_empty;
    logic        r_dmc_silent,     n_dmc_silent;
    logic [4:0]  r_enables,        n_enables;
    logic [7:0]  r_frame_mode,     n_frame_mode;
    logic [15:0] r_frame_cycle,    n_frame_cycle;
    logic        r_frm_int,        n_frm_int;
    logic        r_dmc_irq,        n_dmc_irq;
    logic        r_parity,         n_parity;

    logic        r_out_valid;
    t_out_word   r_out_word;
    t_out_word   n_out_word;
    t_lvl_state  lvl_st;
    logic        accept;
    logic [7:0]  rd;
    logic [2:0]  stall;
    logic        want;
    logic [3:0]  lvl_p1, lvl_p2, lvl_tri, lvl_noise;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        logic        quarter;
        logic        half;
        logic [7:0]  ctl;
        logic [7:0]  data;
        logic [4:0]  off;
        logic [15:0] goal;
        logic [10:0] per;
        logic        fb;

        for (int i = 0; i < 8; i++) n_pulse_reg[i] = r_pulse_reg[i];
        for (int i = 0; i < 4; i++) begin
            n_tri_reg[i]   = r_tri_reg[i];
            n_noise_reg[i] = r_noise_reg[i];
            n_dmc_reg[i]   = r_dmc_reg[i];
            n_len[i]       = r_len[i];
        end
        for (int i = 0; i < 3; i++) begin
            n_env_start[i] = r_env_start[i];
            n_env_div[i]   = r_env_div[i];
            n_env_decay[i] = r_env_decay[i];
        end
        for (int i = 0; i < 2; i++) begin
            n_sweep_div[i] = r_sweep_div[i];
            n_sweep_rld[i] = r_sweep_rld[i];
            n_pulse_cnt[i] = r_pulse_cnt[i];
            n_duty_step[i] = r_duty_step[i];
        end
        n_tri_cnt     = r_tri_cnt;
        n_tri_step    = r_tri_step;
        n_linear      = r_linear;
        n_linear_rld  = r_linear_rld;
        n_noise_cnt   = r_noise_cnt;
        n_lfsr        = r_lfsr;
        n_dmc_cnt     = r_dmc_cnt;
        n_dmc_out     = r_dmc_out;
        n_dmc_addr    = r_dmc_addr;
        n_dmc_left    = r_dmc_left;
        n_dmc_shift   = r_dmc_shift;
        n_dmc_bits    = r_dmc_bits;
        n_dmc_buf     = r_dmc_buf;
        n_dmc_empty   = r_dmc_empty;
        n_dmc_silent  = r_dmc_silent;
        n_enables     = r_enables;
        n_frame_mode  = r_frame_mode;
        n_frame_cycle = r_frame_cycle;
        n_frm_int     = r_frm_int;
        n_dmc_irq     = r_dmc_irq;
        n_parity      = r_parity;

        quarter = 1'b0;
        half    = 1'b0;
        rd      = '0;
        stall   = '0;
        data    = i_in_word.write_data;
        off     = i_in_word.reg_offset;
        ctl     = '0;
        goal    = '0;
        per     = '0;
        fb      = 1'b0;

        unique case (t_cmd'(i_in_word.command))
            CMD_WRITE: begin
                if (off < OFF_PULSE_END) begin
                    n_pulse_reg[off[2:0]] = data;
                    if (off[1:0] == 2'd1) n_sweep_rld[off[2]] = 1'b1;
                    if (off[1:0] == 2'd3) begin
                        if (r_enables[off[2]]) n_len[off[2]] = LEN_LUT[data[7:3]];
                        n_env_start[off[2]] = 1'b1;
                        n_duty_step[off[2]] = '0;
                        n_pulse_cnt[off[2]] = {data[2:0], n_pulse_reg[{off[2], 2'd2}]};
                    end
                end else if (off < OFF_TRI_END) begin
                    n_tri_reg[off[1:0]] = data;
                    if (off == OFF_TRI_HI) begin
                        if (r_enables[2]) n_len[2] = LEN_LUT[data[7:3]];
                        n_linear_rld = 1'b1;
                        n_tri_step   = '0;
                        n_tri_cnt    = {data[2:0], r_tri_reg[2]};
                    end
                end else if (off < OFF_NOISE_END) begin
                    n_noise_reg[off[1:0]] = data;
                    if (off == OFF_NOISE_HI) begin
                        if (r_enables[3]) n_len[3] = LEN_LUT[data[7:3]];
                        n_env_start[2] = 1'b1;
                        n_noise_cnt    = NOISE_LUT[r_noise_reg[2][3:0]];
                    end
                end else if (off < OFF_DMC_END) begin
                    n_dmc_reg[off[1:0]] = data;
                    if (off == OFF_DMC_CTRL) begin
                        if (!data[7]) n_dmc_irq = 1'b0;
                        n_dmc_cnt = RATE_LUT[data[3:0]];
                    end
                    if (off == OFF_DMC_LEVEL) n_dmc_out = data[6:0];
                end else if (off == OFF_STATUS) begin
                    n_enables = data[4:0];
                    n_dmc_irq = 1'b0;
                    for (int i = 0; i < 4; i++) begin
                        if (!data[i]) n_len[i] = '0;
                    end
                    if (!data[4]) begin
                        n_dmc_left = '0;
                    end else if (r_dmc_left == '0) begin
                        n_dmc_addr = DMC_BASE + {2'd0, r_dmc_reg[2], 6'd0};
                        n_dmc_left = {r_dmc_reg[3], 4'd1};
                    end
                end else if (off == OFF_FRAME) begin
                    n_frame_mode  = data;
                    n_frame_cycle = '0;
                    if (data[6]) n_frm_int = 1'b0;
                    quarter = data[7];
                    half    = data[7];
                end
            end
            CMD_READ: begin
                for (int i = 0; i < 4; i++) rd[i] = (r_len[i] != '0);
                rd[4] = (r_dmc_left != '0);
                rd[6] = r_frm_int;
                rd[7] = r_dmc_irq;
                n_frm_int = 1'b0;
            end
            CMD_TICK: begin
                n_parity      = !r_parity;
                n_frame_cycle = r_frame_cycle + 16'd1;
                if (n_frame_cycle == FRAME_Q1 || n_frame_cycle == FRAME_Q3) begin
                    quarter = 1'b1;
                end else if (n_frame_cycle == FRAME_Q2) begin
                    quarter = 1'b1;
                    half    = 1'b1;
                end else if (r_frame_mode[7] && n_frame_cycle == FRAME_END5) begin
                    quarter       = 1'b1;
                    half          = 1'b1;
                    n_frame_cycle = '0;
                end else if (!r_frame_mode[7] && n_frame_cycle == FRAME_END4) begin
                    quarter       = 1'b1;
                    half          = 1'b1;
                    if (!r_frame_mode[6]) n_frm_int = 1'b1;
                    n_frame_cycle = '0;
                end
            end
            CMD_DELIVER: begin
                if (r_dmc_empty && r_dmc_left != '0) begin
                    n_dmc_buf   = data;
                    n_dmc_empty = 1'b0;
                    stall       = STALL_FETCH;
                    n_dmc_addr  = (r_dmc_addr == DMC_WRAP_FROM) ? DMC_WRAP_TO
                                                                : r_dmc_addr + 16'd1;
                    n_dmc_left  = r_dmc_left - 12'd1;
                    if (n_dmc_left == '0) begin
                        if (r_dmc_reg[0][6]) begin
                            n_dmc_addr = DMC_BASE + {2'd0, r_dmc_reg[2], 6'd0};
                            n_dmc_left = {r_dmc_reg[3], 4'd1};
                        end else if (r_dmc_reg[0][7]) begin
                            n_dmc_irq = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // envelopes and linear counter
        if (quarter) begin
            for (int e = 0; e < 3; e++) begin
                ctl = (e == 2) ? n_noise_reg[0] : n_pulse_reg[e * 4];
                if (n_env_start[e]) begin
                    n_env_start[e] = 1'b0;
                    n_env_decay[e] = 4'd15;
                    n_env_div[e]   = ctl[3:0];
                end else if (n_env_div[e] == '0) begin
                    n_env_div[e] = ctl[3:0];
                    if (n_env_decay[e] != '0) n_env_decay[e] = n_env_decay[e] - 4'd1;
                    else if (ctl[5])          n_env_decay[e] = 4'd15;
                end else begin
                    n_env_div[e] = n_env_div[e] - 4'd1;
                end
            end
            if (n_linear_rld)          n_linear = n_tri_reg[0][6:0];
            else if (n_linear != '0)   n_linear = n_linear - 7'd1;
            if (!n_tri_reg[0][7])      n_linear_rld = 1'b0;
        end

        // length counters and sweeps
        if (half) begin
            if (!n_pulse_reg[0][5] && n_len[0] != '0) n_len[0] = n_len[0] - 8'd1;
            if (!n_pulse_reg[4][5] && n_len[1] != '0) n_len[1] = n_len[1] - 8'd1;
            if (!n_tri_reg[0][7]   && n_len[2] != '0) n_len[2] = n_len[2] - 8'd1;
            if (!n_noise_reg[0][5] && n_len[3] != '0) n_len[3] = n_len[3] - 8'd1;
            for (int ch = 0; ch < 2; ch++) begin
                ctl  = n_pulse_reg[ch * 4 + 1];
                per  = {n_pulse_reg[ch * 4 + 3][2:0], n_pulse_reg[ch * 4 + 2]};
                goal = sweep_goal(per, ctl, ch == 0);
                if (n_sweep_div[ch] == '0 && ctl[7] && ctl[2:0] != '0 &&
                    per >= 11'd8 && goal <= PERIOD_MAX) begin
                    n_pulse_reg[ch * 4 + 2] = goal[7:0];
                    n_pulse_reg[ch * 4 + 3] = {n_pulse_reg[ch * 4 + 3][7:3], goal[10:8]};
                end
                if (n_sweep_div[ch] == '0 || n_sweep_rld[ch]) begin
                    n_sweep_div[ch] = ctl[6:4];
                    n_sweep_rld[ch] = 1'b0;
                end else begin
                    n_sweep_div[ch] = n_sweep_div[ch] - 3'd1;
                end
            end
        end

        if (t_cmd'(i_in_word.command) == CMD_TICK) begin
            // triangle sequencer
            if (n_tri_cnt == '0) begin
                n_tri_cnt = {n_tri_reg[3][2:0], n_tri_reg[2]};
                if (n_len[2] != '0 && n_linear != '0) n_tri_step = n_tri_step + 5'd1;
            end else begin
                n_tri_cnt = n_tri_cnt - 11'd1;
            end
            // sample reader
            if (n_enables[4]) begin
                if (n_dmc_cnt != '0) begin
                    n_dmc_cnt = n_dmc_cnt - 9'd1;
                end else begin
                    n_dmc_cnt = RATE_LUT[n_dmc_reg[0][3:0]];
                    if (!n_dmc_silent) begin
                        if (n_dmc_shift[0]) begin
                            if (n_dmc_out <= DMC_TOP) n_dmc_out = n_dmc_out + 7'd2;
                        end else if (n_dmc_out >= 7'd2) begin
                            n_dmc_out = n_dmc_out - 7'd2;
                        end
                    end
                    n_dmc_shift = n_dmc_shift >> 1;
                    n_dmc_bits  = n_dmc_bits - 4'd1;
                    if (n_dmc_bits == '0) begin
                        n_dmc_bits = 4'd8;
                        if (n_dmc_empty) begin
                            n_dmc_silent = 1'b1;
                        end else begin
                            n_dmc_silent = 1'b0;
                            n_dmc_shift  = n_dmc_buf;
                            n_dmc_empty  = 1'b1;
                        end
                    end
                end
            end
            // pulse and noise timers run at half rate
            if (!n_parity) begin
                for (int ch = 0; ch < 2; ch++) begin
                    if (n_pulse_cnt[ch] == '0) begin
                        n_pulse_cnt[ch] = {n_pulse_reg[ch * 4 + 3][2:0], n_pulse_reg[ch * 4 + 2]};
                        n_duty_step[ch] = n_duty_step[ch] + 3'd1;
                    end else begin
                        n_pulse_cnt[ch] = n_pulse_cnt[ch] - 11'd1;
                    end
                end
                if (n_noise_cnt == '0) begin
                    fb          = n_lfsr[0] ^ (n_noise_reg[2][7] ? n_lfsr[6] : n_lfsr[1]);
                    n_lfsr      = {fb, n_lfsr[14:1]};
                    n_noise_cnt = NOISE_LUT[n_noise_reg[2][3:0]];
                end else begin
                    n_noise_cnt = n_noise_cnt - 12'd1;
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 2; ch++) begin
            lvl_st.pulse_ctl[ch]    = n_pulse_reg[ch * 4];
            lvl_st.sweep_ctl[ch]    = n_pulse_reg[ch * 4 + 1];
            lvl_st.pulse_period[ch] = {n_pulse_reg[ch * 4 + 3][2:0], n_pulse_reg[ch * 4 + 2]};
            lvl_st.duty_step[ch]    = n_duty_step[ch];
        end
        for (int e = 0; e < 3; e++) lvl_st.env_decay[e] = n_env_decay[e];
        for (int i = 0; i < 4; i++) lvl_st.len_nz[i] = (n_len[i] != '0);
        lvl_st.enables    = n_enables;
        lvl_st.tri_period = {n_tri_reg[3][2:0], n_tri_reg[2]};
        lvl_st.tri_step   = n_tri_step;
        lvl_st.linear_nz  = (n_linear != '0);
        lvl_st.noise_ctl  = n_noise_reg[0];
        lvl_st.lfsr_lsb   = n_lfsr[0];
    end

    sgrc_levels u_levels (
        .i_st        (lvl_st),
        .o_pulse_one (lvl_p1),
        .o_pulse_two (lvl_p2),
        .o_triangle  (lvl_tri),
        .o_noise     (lvl_noise)
    );

    assign want = n_dmc_empty && (n_dmc_left != '0);

    always_comb begin
        n_out_word.read_data       = rd;
        n_out_word.irq_line        = n_frm_int || n_dmc_irq;
        n_out_word.fetch_request   = want;
        n_out_word.fetch_address   = want ? n_dmc_addr : '0;
        n_out_word.stall_cycles    = stall;
        n_out_word.pulse_one_level = lvl_p1;
        n_out_word.pulse_two_level = lvl_p2;
        n_out_word.triangle_level  = lvl_tri;
        n_out_word.noise_level     = lvl_noise;
        n_out_word.sample_level    = n_dmc_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_pulse_reg[i] <= '0;
            for (int i = 0; i < 4; i++) begin
                r_tri_reg[i]   <= '0;
                r_noise_reg[i] <= '0;
                r_dmc_reg[i]   <= '0;
                r_len[i]       <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_env_start[i] <= 1'b0;
                r_env_div[i]   <= '0;
                r_env_decay[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_sweep_div[i] <= '0;
                r_sweep_rld[i] <= 1'b0;
                r_pulse_cnt[i] <= '0;
                r_duty_step[i] <= '0;
            end
            r_tri_cnt     <= '0;
            r_tri_step    <= '0;
            r_linear      <= '0;
            r_linear_rld  <= 1'b0;
            r_noise_cnt   <= '0;
            r_lfsr        <= 15'd1;
            r_dmc_cnt     <= '0;
            r_dmc_out     <= '0;
            r_dmc_addr    <= '0;
            r_dmc_left    <= '0;
            r_dmc_shift   <= '0;
            r_dmc_bits    <= 4'd8;
            r_dmc_buf     <= '0;
            r_dmc_empty   <= 1'b1;
            r_dmc_silent  <= 1'b1;
            r_enables     <= '0;
            r_frame_mode  <= '0;
            r_frame_cycle <= '0;
            r_frm_int     <= 1'b0;
            r_dmc_irq     <= 1'b0;
            r_parity      <= 1'b0;
        end else if (accept) begin
            for (int i = 0; i < 8; i++) r_pulse_reg[i] <= n_pulse_reg[i];
            for (int i = 0; i < 4; i++) begin
                r_tri_reg[i]   <= n_tri_reg[i];
                r_noise_reg[i] <= n_noise_reg[i];
                r_dmc_reg[i]   <= n_dmc_reg[i];
                r_len[i]       <= n_len[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_env_start[i] <= n_env_start[i];
                r_env_div[i]   <= n_env_div[i];
                r_env_decay[i] <= n_env_decay[i];
            end
            for (int i = 0; i < 2; i++) begin
                r_sweep_div[i] <= n_sweep_div[i];
                r_sweep_rld[i] <= n_sweep_rld[i];
                r_pulse_cnt[i] <= n_pulse_cnt[i];
                r_duty_step[i] <= n_duty_step[i];
            end
            r_tri_cnt     <= n_tri_cnt;
            r_tri_step    <= n_tri_step;
            r_linear      <= n_linear;
            r_linear_rld  <= n_linear_rld;
            r_noise_cnt   <= n_noise_cnt;
            r_lfsr        <= n_lfsr;
            r_dmc_cnt     <= n_dmc_cnt;
            r_dmc_out     <= n_dmc_out;
            r_dmc_addr    <= n_dmc_addr;
            r_dmc_left    <= n_dmc_left;
            r_dmc_shift   <= n_dmc_shift;
            r_dmc_bits    <= n_dmc_bits;
            r_dmc_buf     <= n_dmc_buf;
            r_dmc_empty   <= n_dmc_empty;
            r_dmc_silent  <= n_dmc_silent;
            r_enables     <= n_enables;
            r_frame_mode  <= n_frame_mode;
            r_frame_cycle <= n_frame_cycle;
            r_frm_int     <= n_frm_int;
            r_dmc_irq     <= n_dmc_irq;
            r_parity      <= n_parity;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* design/sgrc_checker.sv */
// Port-level checks on the sound generator core and their bind to it.
`timescale 1ns / 1ps
module sgrc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input sgrc_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input sgrc_pkg::t_out_word o_out_word
);
    import sgrc_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input blocked while output register free");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted word gave no result");

    a_addr_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.fetch_request) |-> (o_out_word.fetch_address == 16'd0))
        else $error("fetch address without request");

    a_stall_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.stall_cycles == 3'd0 ||
                         o_out_word.stall_cycles == STALL_FETCH))
        else $error("bad stall count");

endmodule

bind sound_generator_register_core sgrc_checker u_sgrc_checker (.*);
